[hw/rtl/reduced_axes_index_mapper_defines.svh]
// assertion macros for the reduced axes index mapper
`ifndef REDUCED_AXES_INDEX_MAPPER_DEFINES_SVH
`define REDUCED_AXES_INDEX_MAPPER_DEFINES_SVH

`ifndef SYNTHESIS

`define RAMI_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rami assertion failed");

`define RAMI_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rami assertion failed");

`else

`define RAMI_ASSERT_IMP(label, clk, rst, ante, cons)

`define RAMI_ASSERT_NXT(label, clk, rst, ante, cons)

`endif

`endif

[hw/rtl/rami_pkg.sv]
`timescale 1ns / 1ps

package rami_pkg;

   localparam int INDEX_BITS    = 32;
   localparam int SIZE_BITS     = 16;
   localparam int MAX_DIMS      = 4;
   localparam int CNT_BITS      = 3;
   localparam int MASK_BITS     = 4;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;
   localparam int MAC_BITS      = INDEX_BITS + SIZE_BITS;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_DIM_COUNT = 3'd0,
      CSR_RED_MASK  = 3'd1,
      CSR_SIZE_DIM1 = 3'd2,
      CSR_SIZE_DIM2 = 3'd3,
      CSR_SIZE_DIM3 = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic                  vld;
      logic [SIZE_BITS-1:0]  rem;
      logic [INDEX_BITS-1:0] work;
      logic [INDEX_BITS-1:0] acc;
      logic [INDEX_BITS-1:0] mult;
   } cell_type;

   typedef struct packed {
      logic                  vld;
      logic [INDEX_BITS-1:0] rest;
      logic [INDEX_BITS-1:0] acc;
      logic [INDEX_BITS-1:0] prod;
      logic [INDEX_BITS-1:0] mult;
   } mac_type;

   typedef struct packed {
      logic                    vld;
      logic [INDEX_BITS-1:0]   acc;
      logic [2*INDEX_BITS-1:0] prod;
   } fin_type;

   typedef struct packed {
      logic                  vld;
      logic [INDEX_BITS-1:0] idx;
      logic                  ovf;
   } res_type;

endpackage

[hw/rtl/rami_ifs.sv]
`timescale 1ns / 1ps

interface rami_req_if;
   logic                            valid;
   logic                            ready;
   logic [rami_pkg::INDEX_BITS-1:0] flat_index;
   modport source (output valid, output flat_index, input ready);
   modport sink (input valid, input flat_index, output ready);
endinterface

interface rami_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [rami_pkg::INDEX_BITS-1:0] reduced_index;
   logic                            overflow;
   modport source (output valid, output reduced_index, output overflow, input ready);
   modport sink (input valid, input reduced_index, input overflow, output ready);
endinterface

[hw/rtl/reduced_axes_index_mapper.sv]
// channel  dir  handshake      word
// req      in   valid/ready    flat_index[31:0]
// rsp      out  valid/ready    reduced_index[31:0], overflow
// csr      in   csr_we         csr_index[2:0], csr_wdata[15:0]
//
// one word accepted per cycle while the chain is not stalled
// three 32-cell divider chains, each followed by multiply and add
// then a final multiply and a saturating add
// one shared stall: the whole chain holds while rsp is full and not taken
// synchronous reset clears the valid bits and loads the register defaults
`timescale 1ns / 1ps
`include "reduced_axes_index_mapper_defines.svh"

module reduced_axes_index_mapper (
   input  logic                               clock,
   input  logic                               reset,
   rami_req_if.sink                           req,
   rami_rsp_if.source                         rsp,
   input  logic                               csr_we,
   input  logic [rami_pkg::CSR_IDX_BITS-1:0]  csr_index,
   input  logic [rami_pkg::CSR_DATA_BITS-1:0] csr_wdata
);

   localparam int NS = rami_pkg::MAX_DIMS - 1;

   logic [rami_pkg::CNT_BITS-1:0]  dim_count_ff;
   logic [rami_pkg::MASK_BITS-1:0] mask_ff;
   logic [rami_pkg::SIZE_BITS-1:0] size_ff [1:NS];
   logic [rami_pkg::CNT_BITS-1:0]  n_dims;
   logic [rami_pkg::SIZE_BITS-1:0] size_eff [1:NS];
   logic                           kept [0:NS];
   logic                           adv;
   rami_pkg::cell_type             chain [0:NS];
   rami_pkg::fin_type              fin_in;
   rami_pkg::fin_type              fin_ff;
   rami_pkg::res_type              res_in;
   rami_pkg::res_type              res_ff;
   logic [rami_pkg::INDEX_BITS:0]  sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         dim_count_ff <= rami_pkg::CNT_BITS'(1);
         mask_ff <= '0;
         for (int i = 1; i <= NS; i++) begin
            size_ff[i] <= rami_pkg::SIZE_BITS'(1);
         end
      end else if (csr_we) begin
         unique case (csr_index)
            rami_pkg::CSR_DIM_COUNT: dim_count_ff <= csr_wdata[rami_pkg::CNT_BITS-1:0];
            rami_pkg::CSR_RED_MASK:  mask_ff <= csr_wdata[rami_pkg::MASK_BITS-1:0];
            rami_pkg::CSR_SIZE_DIM1: size_ff[1] <= csr_wdata[rami_pkg::SIZE_BITS-1:0];
            rami_pkg::CSR_SIZE_DIM2: size_ff[2] <= csr_wdata[rami_pkg::SIZE_BITS-1:0];
            rami_pkg::CSR_SIZE_DIM3: size_ff[3] <= csr_wdata[rami_pkg::SIZE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // absent dimensions divide by one and are skipped; zero dims keep dim 0
   always_comb begin
      n_dims = (dim_count_ff > rami_pkg::CNT_BITS'(rami_pkg::MAX_DIMS))
               ? rami_pkg::CNT_BITS'(rami_pkg::MAX_DIMS) : dim_count_ff;
      kept[0] = (n_dims == '0) || !mask_ff[0];
      for (int d = 1; d <= NS; d++) begin
         kept[d] = (rami_pkg::CNT_BITS'(d) < n_dims) && !mask_ff[d];
         size_eff[d] = ((rami_pkg::CNT_BITS'(d) < n_dims) && (size_ff[d] != '0))
                       ? size_ff[d] : rami_pkg::SIZE_BITS'(1);
      end
   end

   assign adv = !res_ff.vld || rsp.ready;
   assign req.ready = adv;

   always_comb begin
      chain[0].vld = req.valid;
      chain[0].rem = '0;
      chain[0].work = req.flat_index;
      chain[0].acc = '0;
      chain[0].mult = rami_pkg::INDEX_BITS'(1);
   end

   for (genvar j = 0; j < NS; j++) begin : g_dim
      rami_dim_stage u_dim (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .size   (size_eff[NS-j]),
         .kept   (kept[NS-j]),
         .cell_i (chain[j]),
         .cell_o (chain[j+1])
      );
   end

   always_comb begin
      fin_in.vld = chain[NS].vld;
      fin_in.acc = chain[NS].acc;
      fin_in.prod = {{rami_pkg::INDEX_BITS{1'b0}}, chain[NS].work}
                    * {{rami_pkg::INDEX_BITS{1'b0}}, chain[NS].mult};
   end

   always_comb begin
      sum = {1'b0, fin_ff.acc} + {1'b0, fin_ff.prod[rami_pkg::INDEX_BITS-1:0]};
      res_in.vld = fin_ff.vld;
      if (kept[0]) begin
         res_in.ovf = (fin_ff.prod[2*rami_pkg::INDEX_BITS-1:rami_pkg::INDEX_BITS] != '0)
                      || sum[rami_pkg::INDEX_BITS];
         res_in.idx = res_in.ovf ? '1 : sum[rami_pkg::INDEX_BITS-1:0];
      end else begin
         res_in.ovf = 1'b0;
         res_in.idx = fin_ff.acc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_ff.vld <= 1'b0;
         res_ff.vld <= 1'b0;
      end else if (adv) begin
         fin_ff <= fin_in;
         res_ff <= res_in;
      end
   end

   assign rsp.valid = res_ff.vld;
   assign rsp.reduced_index = res_ff.idx;
   assign rsp.overflow = res_ff.ovf;

   `RAMI_ASSERT_IMP(a_ovf_sat, clock, reset, rsp.valid && rsp.overflow, rsp.reduced_index == '1)
   `RAMI_ASSERT_IMP(a_stall, clock, reset, rsp.valid && !rsp.ready, !req.ready)
   `RAMI_ASSERT_IMP(a_empty_ready, clock, reset, !rsp.valid, req.ready)
   `RAMI_ASSERT_NXT(a_hold, clock, reset, rsp.valid && !rsp.ready, $stable(fin_ff))

endmodule

[hw/rtl/rami_div_cell.sv]
`timescale 1ns / 1ps

module rami_div_cell (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic [rami_pkg::SIZE_BITS-1:0] size,
   input  rami_pkg::cell_type             cell_i,
   output rami_pkg::cell_type             cell_o
);

   logic [rami_pkg::SIZE_BITS:0] trial;
   logic [rami_pkg::SIZE_BITS:0] diff;
   logic                         ge;
   rami_pkg::cell_type           cell_in;
   rami_pkg::cell_type           cell_ff;

   // one restoring step: shift in the next dividend bit, subtract when it fits
   always_comb begin
      trial = {cell_i.rem, cell_i.work[rami_pkg::INDEX_BITS-1]};
      diff = trial - {1'b0, size};
      ge = trial >= {1'b0, size};
      cell_in = cell_i;
      cell_in.rem = ge ? diff[rami_pkg::SIZE_BITS-1:0] : trial[rami_pkg::SIZE_BITS-1:0];
      cell_in.work = {cell_i.work[rami_pkg::INDEX_BITS-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_ff.vld <= 1'b0;
      end else if (adv) begin
         cell_ff <= cell_in;
      end
   end

   assign cell_o = cell_ff;

endmodule

[hw/rtl/rami_dim_stage.sv]
`timescale 1ns / 1ps

module rami_dim_stage (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           adv,
   input  logic [rami_pkg::SIZE_BITS-1:0] size,
   input  logic                           kept,
   input  rami_pkg::cell_type             cell_i,
   output rami_pkg::cell_type             cell_o
);

   rami_pkg::cell_type                link [0:rami_pkg::INDEX_BITS];
   rami_pkg::cell_type                last;
   rami_pkg::mac_type                 mac_in;
   rami_pkg::mac_type                 mac_ff;
   rami_pkg::cell_type                out_in;
   rami_pkg::cell_type                out_ff;
   logic [rami_pkg::MAC_BITS-1:0]     digit_prod;
   logic [rami_pkg::MAC_BITS-1:0]     mult_prod;

   always_comb begin
      link[0] = cell_i;
      link[0].rem = '0;
   end

   for (genvar k = 0; k < rami_pkg::INDEX_BITS; k++) begin : g_cell
      rami_div_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .size   (size),
         .cell_i (link[k]),
         .cell_o (link[k+1])
      );
   end

   assign last = link[rami_pkg::INDEX_BITS];

   // digit times multiplier; for a kept axis the multiplier grows by this size
   always_comb begin
      digit_prod = {{(rami_pkg::MAC_BITS-rami_pkg::SIZE_BITS){1'b0}}, last.rem}
                   * {{(rami_pkg::MAC_BITS-rami_pkg::INDEX_BITS){1'b0}}, last.mult};
      mult_prod = {{(rami_pkg::MAC_BITS-rami_pkg::SIZE_BITS){1'b0}}, size}
                  * {{(rami_pkg::MAC_BITS-rami_pkg::INDEX_BITS){1'b0}}, last.mult};
      mac_in.vld = last.vld;
      mac_in.rest = last.work;
      mac_in.acc = last.acc;
      mac_in.prod = digit_prod[rami_pkg::INDEX_BITS-1:0];
      mac_in.mult = kept ? mult_prod[rami_pkg::INDEX_BITS-1:0] : last.mult;
   end

   always_comb begin
      out_in.vld = mac_ff.vld;
      out_in.rem = '0;
      out_in.work = mac_ff.rest;
      out_in.acc = kept ? mac_ff.acc + mac_ff.prod : mac_ff.acc;
      out_in.mult = mac_ff.mult;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mac_ff.vld <= 1'b0;
         out_ff.vld <= 1'b0;
      end else if (adv) begin
         mac_ff <= mac_in;
         out_ff <= out_in;
      end
   end

   assign cell_o = out_ff;

endmodule

[dv/reduced_axes_index_mapper_tb.sv]
`timescale 1ns / 1ps

module reduced_axes_index_mapper_tb;

   typedef struct packed {
      logic [rami_pkg::INDEX_BITS-1:0] idx;
      logic                            ovf;
   } reduced_word_type;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 150;

   logic clock;
   logic reset;
   logic csr_we;
   logic [rami_pkg::CSR_IDX_BITS-1:0]  csr_index;
   logic [rami_pkg::CSR_DATA_BITS-1:0] csr_wdata;

   rami_req_if req ();
   rami_rsp_if rsp ();

   reduced_axes_index_mapper u_dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req.sink),
      .rsp       (rsp.source),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // shadow copy of the registers
   logic [rami_pkg::CNT_BITS-1:0]  dim_count_q;
   logic [rami_pkg::MASK_BITS-1:0] red_mask_q;
   logic [rami_pkg::SIZE_BITS-1:0] size_q [1:3];

   reduced_word_type expected_reduced [$];
   int mismatches;
   int words_sent;
   int words_checked;
   int csr_writes;
   int idle_cycles;
   int send_idle_pct;
   int recv_idle_pct;

   always begin
      clock = 1'b1;
      #6;
      clock = 1'b0;
      #6;
   end

   function automatic reduced_word_type map_flat_index(
      logic [rami_pkg::INDEX_BITS-1:0] flat);
      reduced_word_type res;
      logic [63:0] limit;
      logic [63:0] rest;
      logic [63:0] acc;
      logic [63:0] mult;
      logic [63:0] s;
      logic [63:0] digit;
      int n;
      limit = 64'hFFFF_FFFF;
      rest  = {32'd0, flat};
      acc   = 64'd0;
      mult  = 64'd1;
      res.ovf = 1'b0;
      n = (dim_count_q > rami_pkg::MAX_DIMS) ? rami_pkg::MAX_DIMS : int'(dim_count_q);
      if (n == 0) begin
         res.idx = flat;
         return res;
      end
      for (int d = n - 1; d > 0; d--) begin
         s = (size_q[d] == 0) ? 64'd1 : {48'd0, size_q[d]};
         digit = rest % s;
         rest = rest / s;
         if (!red_mask_q[d]) begin
            acc = acc + digit * mult;
            mult = mult * s;
         end
      end
      if (!red_mask_q[0] && rest != 0) begin
         if (acc > limit || mult > (limit - acc) / rest) begin
            res.ovf = 1'b1;
            acc = limit;
         end else begin
            acc = acc + rest * mult;
         end
      end
      if (acc > limit) begin
         res.ovf = 1'b1;
         acc = limit;
      end
      res.idx = acc[rami_pkg::INDEX_BITS-1:0];
      return res;
   endfunction

   // prediction on accept, compare on result
   always @(posedge clock) begin
      reduced_word_type exp_word;
      if (!reset && req.valid && req.ready) begin
         expected_reduced.push_back(map_flat_index(req.flat_index));
      end
      if (!reset && rsp.valid && rsp.ready) begin
         words_checked++;
         if (expected_reduced.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("unexpected word idx=%h ovf=%b", rsp.reduced_index, rsp.overflow);
            end
         end else begin
            exp_word = expected_reduced.pop_front();
            if (rsp.reduced_index !== exp_word.idx || rsp.overflow !== exp_word.ovf) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch: expected idx=%h ovf=%b, got idx=%h ovf=%b",
                           exp_word.idx, exp_word.ovf, rsp.reduced_index, rsp.overflow);
               end
            end
         end
      end
   end

   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("reduced_axes_index_mapper_tb NOT OK");
            $finish;
         end
      end
   end

   task automatic send_flat_index(logic [rami_pkg::INDEX_BITS-1:0] flat);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid      <= 1'b1;
      req.flat_index <= flat;
      do @(posedge clock); while (!req.ready);
      words_sent++;
      @(negedge clock);
   endtask

   task automatic wait_idle();
      req.valid <= 1'b0;
      while (expected_reduced.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   // write enable stays high; the caller drops it after the last write
   task automatic write_csr(rami_pkg::csr_index_type idx,
                            logic [rami_pkg::CSR_DATA_BITS-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(negedge clock);
      csr_writes++;
      case (idx)
         rami_pkg::CSR_DIM_COUNT: dim_count_q = data[rami_pkg::CNT_BITS-1:0];
         rami_pkg::CSR_RED_MASK:  red_mask_q  = data[rami_pkg::MASK_BITS-1:0];
         rami_pkg::CSR_SIZE_DIM1: size_q[1]   = data;
         rami_pkg::CSR_SIZE_DIM2: size_q[2]   = data;
         rami_pkg::CSR_SIZE_DIM3: size_q[3]   = data;
         default: ;
      endcase
   endtask

   task automatic set_shape(int cnt, int mask, int s1, int s2, int s3);
      wait_idle();
      write_csr(rami_pkg::CSR_DIM_COUNT, rami_pkg::CSR_DATA_BITS'(cnt));
      write_csr(rami_pkg::CSR_RED_MASK, rami_pkg::CSR_DATA_BITS'(mask));
      write_csr(rami_pkg::CSR_SIZE_DIM1, rami_pkg::CSR_DATA_BITS'(s1));
      write_csr(rami_pkg::CSR_SIZE_DIM2, rami_pkg::CSR_DATA_BITS'(s2));
      write_csr(rami_pkg::CSR_SIZE_DIM3, rami_pkg::CSR_DATA_BITS'(s3));
      csr_we <= 1'b0;
   endtask

   task automatic test_reset_defaults();
      send_flat_index(32'h0000_0000);
      send_flat_index(32'hFFFF_FFFF);
      send_flat_index(32'hA5A5_5A5A);
   endtask

   task automatic test_zero_dims();
      set_shape(0, 15, 7, 9, 11);
      send_flat_index(32'hFFFF_FFFF);
      send_flat_index(32'h1234_5678);
   endtask

   task automatic test_size_extremes();
      set_shape(4, 0, 65535, 65535, 65535);
      send_flat_index(32'hFFFF_FFFF);
      send_flat_index(32'h0001_0000);
      send_flat_index(32'h0000_0000);
      set_shape(4, 4'b1010, 0, 65535, 1);
      send_flat_index(32'hFFFF_FFFF);
      send_flat_index(32'h8765_4321);
      set_shape(4, 4'b0001, 3, 5, 7);
      send_flat_index(32'hFFFF_FFFF);
      send_flat_index(32'd104);
   endtask

   task automatic test_oversize_count();
      set_shape(7, 15, 2, 3, 4);
      send_flat_index(32'hDEAD_BEEF);
      set_shape(5, 4'b0110, 10, 100, 1000);
      send_flat_index(32'h7FFF_FFFF);
      send_flat_index(32'd123456);
   endtask

   task automatic test_absent_mask_bits();
      set_shape(2, 4'b1100, 300, 65535, 65535);
      send_flat_index(32'hFFFF_FFFF);
      send_flat_index(32'd299);
      set_shape(3, 4'b1001, 17, 65535, 9);
      send_flat_index(32'h4000_0001);
   endtask

   function automatic int pick_size();
      case ($urandom_range(5))
         0: return 0;
         1: return 65535;
         2: return 1;
         3: return $urandom_range(65535);
         default: return $urandom_range(2, 40);
      endcase
   endfunction

   task automatic test_random_phase(int items, int sidle, int ridle);
      logic [rami_pkg::INDEX_BITS-1:0] flat;
      send_idle_pct = sidle;
      recv_idle_pct = ridle;
      for (int i = 0; i < items; i++) begin
         if (i % 40 == 0) begin
            set_shape($urandom_range(7), $urandom_range(15),
                      pick_size(), pick_size(), pick_size());
         end
         case ($urandom_range(3))
            0: flat = $urandom_range(5000);
            1: flat = {16'($urandom_range(65535)), 16'($urandom_range(65535))};
            default: flat = $urandom();
         endcase
         send_flat_index(flat);
      end
   endtask

   initial begin
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = rami_pkg::CSR_DIM_COUNT;
      csr_wdata     = '0;
      req.valid     = 1'b0;
      req.flat_index = '0;
      rsp.ready     = 1'b0;
      mismatches    = 0;
      words_sent    = 0;
      words_checked = 0;
      csr_writes    = 0;
      idle_cycles   = 0;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      dim_count_q   = 3'd1;
      red_mask_q    = '0;
      size_q[1]     = 16'd1;
      size_q[2]     = 16'd1;
      size_q[3]     = 16'd1;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_zero_dims();
      test_size_extremes();
      test_oversize_count();
      test_absent_mask_bits();
      test_random_phase(240, 16, 76);
      test_random_phase(240, 76, 16);
      test_random_phase(240, 0, 0);

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_reduced.size() != 0) mismatches++;
      $display("sent %0d flat indexes, checked %0d reduced indexes", words_sent, words_checked);
      $display("%0d register writes across 0..7 dims, all masks, sizes 0..65535", csr_writes);
      if (mismatches == 0) begin
         $display("reduced_axes_index_mapper_tb OK");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("reduced_axes_index_mapper_tb NOT OK");
      end
      $finish;
   end

endmodule
